// File: rtl/core/ecf_pkg.sv
// ----------------------------------------------------------------------------
// ecf_pkg : shared constants and types for the edge crossing finder
// Store sizes, field widths, opcodes, sequencer states and the fixed-point
// types used by the orientation datapath.
// ----------------------------------------------------------------------------
package ecf_pkg;

  // store sizes and coordinate precision
  localparam int NODE_SLOTS = 256;
  localparam int EDGE_SLOTS = 64;
  localparam int COORD_BITS = 16;

  localparam int NODE_AW = $clog2(NODE_SLOTS);
  localparam int EDGE_AW = $clog2(EDGE_SLOTS);

  // field widths on the channels
  localparam int OP_W       = 2;
  localparam int NODE_IDX_W = 8;
  localparam int POS_W      = 16;
  localparam int EDGE_IDX_W = 6;
  localparam int EIU_W      = 7;

  // products per edge pair, and the phase at which the last compare lands
  localparam int PH_W     = 4;
  localparam int PH_ISSUE = 8;
  localparam int PH_LAST  = PH_ISSUE + 1;

  typedef logic signed [COORD_BITS-1:0]   coord_t;
  typedef logic signed [COORD_BITS:0]     diff_t;
  typedef logic signed [2*COORD_BITS+1:0] prod_t;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_NODE = 2'd0,
    OP_LOAD_EDGE = 2'd1,
    OP_SCAN      = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAD_EDGE,
    ST_HEAD_A,
    ST_HEAD_B,
    ST_J_CHECK,
    ST_EDGE_DATA,
    ST_NODE_C,
    ST_NODE_D,
    ST_TEST,
    ST_DECIDE,
    ST_FINISH
  } state_t;

endpackage

// File: rtl/core/ecf_if.sv
// ----------------------------------------------------------------------------
// ecf_if : valid/ready channels of the edge crossing finder
// ecf_in_if carries load and scan commands, ecf_out_if carries results.
// ----------------------------------------------------------------------------
interface ecf_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [ecf_pkg::OP_W-1:0]               op;
  logic [ecf_pkg::NODE_IDX_W-1:0]         node_index;
  logic signed [ecf_pkg::POS_W-1:0]       pos_x;
  logic signed [ecf_pkg::POS_W-1:0]       pos_y;
  logic [ecf_pkg::EDGE_IDX_W-1:0]         edge_index;
  logic [ecf_pkg::NODE_IDX_W-1:0]         end_a;
  logic [ecf_pkg::NODE_IDX_W-1:0]         end_b;

  modport source (
    output valid, op, node_index, pos_x, pos_y, edge_index, end_a, end_b,
    input  ready
  );
  modport sink (
    input  valid, op, node_index, pos_x, pos_y, edge_index, end_a, end_b,
    output ready
  );
endinterface

interface ecf_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [ecf_pkg::EDGE_IDX_W-1:0]         first_edge;
  logic [ecf_pkg::EDGE_IDX_W-1:0]         second_edge;
  logic [ecf_pkg::NODE_IDX_W-1:0]         first_a;
  logic [ecf_pkg::NODE_IDX_W-1:0]         first_b;
  logic [ecf_pkg::NODE_IDX_W-1:0]         second_a;
  logic [ecf_pkg::NODE_IDX_W-1:0]         second_b;
  logic                                   crossing;
  logic                                   last;

  modport source (
    output valid, first_edge, second_edge, first_a, first_b, second_a,
           second_b, crossing, last,
    input  ready
  );
  modport sink (
    input  valid, first_edge, second_edge, first_a, first_b, second_a,
           second_b, crossing, last,
    output ready
  );
endinterface

// File: rtl/core/edge_crossing_finder.sv
// ----------------------------------------------------------------------------
// edge_crossing_finder : proper-crossing search over a stored edge list
// Loads node positions and edges into RAMs; a scan tests one edge against
// every later edge in use and reports each proper crossing in index order, or one empty result if none.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake         | carries
//  ----------+-----+-------------------+-------------------------------------
//  in_chan   | in  | valid/ready       | op, node/edge index, position, ends
//  out_chan  | out | valid/ready       | edge pair, endpoints, crossing, last
//  cfg_*     | in  | cfg_we, no stall  | edges_in_use
//
//  A load needs nothing beyond its transfer, which itself writes the store.
//  A scan runs a full orientation test on each later edge with distinct
//  endpoints and skips each later edge that shares an endpoint. A test reads
//  the nodes of the later edge through the single read port and runs eight
//  products through the one shared multiplier pipeline.
//  in_chan.ready is low for the whole scan; result stalls hold the sequencer.
//  Reset clears control only; stores hold whatever they held.
//
module edge_crossing_finder (
  input  logic                          clk,
  input  logic                          rst_n,
  ecf_in_if.sink                        in_chan,
  ecf_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [ecf_pkg::EIU_W-1:0]     cfg_wdata
);

  localparam int NIW = ecf_pkg::NODE_IDX_W;
  localparam int EIW = ecf_pkg::EDGE_IDX_W;
  localparam int JW  = ecf_pkg::EIU_W;

  // --------------------------------------------------------------------------
  // state and registers
  // --------------------------------------------------------------------------
  ecf_pkg::state_t                  state_r, state_nxt;
  logic [JW-1:0]                    edges_in_use_r;

  logic [EIW-1:0]                   scan_idx_r;
  logic [JW-1:0]                    j_r;
  logic [NIW-1:0]                   fa_r, fb_r, sa_r, sb_r;
  ecf_pkg::coord_t                  ax_r, ay_r, bx_r, by_r;
  ecf_pkg::coord_t                  cx_r, cy_r, dx_r, dy_r;

  // shared orientation pipeline: differences -> product -> compare
  logic [ecf_pkg::PH_W-1:0]         ph_r;
  ecf_pkg::diff_t                   diff_u_r, diff_v_r;
  logic                             diff_vld_r;
  logic [2:0]                       diff_tag_r;
  ecf_pkg::prod_t                   prod_r, p1_r;
  logic                             prod_vld_r;
  logic [2:0]                       prod_tag_r;
  logic [3:0]                       orient_r;

  // one crossing held back until we know whether it is the final one
  logic                             pend_vld_r;
  logic [EIW-1:0]                   pend_edge_r;
  logic [NIW-1:0]                   pend_a_r, pend_b_r;

  // result register
  logic                             out_vld_r;
  logic [EIW-1:0]                   out_first_edge_r, out_second_edge_r;
  logic [NIW-1:0]                   out_first_a_r, out_first_b_r;
  logic [NIW-1:0]                   out_second_a_r, out_second_b_r;
  logic                             out_crossing_r, out_last_r;

  // --------------------------------------------------------------------------
  // stores
  // --------------------------------------------------------------------------
  logic                             in_xfer, node_we, edge_we;
  logic [ecf_pkg::EDGE_AW-1:0]      edge_rd_addr;
  logic [NIW-1:0]                   node_rd_idx;
  logic [NIW-1:0]                   edge_a_rd, edge_b_rd;
  logic [ecf_pkg::COORD_BITS-1:0]   node_x_rd, node_y_rd;
  ecf_pkg::coord_t                  wr_x, wr_y;

  assign in_xfer = in_chan.valid && in_chan.ready;
  assign node_we = in_xfer && (ecf_pkg::op_t'(in_chan.op) == ecf_pkg::OP_LOAD_NODE)
                   && (int'(in_chan.node_index) < ecf_pkg::NODE_SLOTS);
  assign edge_we = in_xfer && (ecf_pkg::op_t'(in_chan.op) == ecf_pkg::OP_LOAD_EDGE)
                   && (int'(in_chan.edge_index) < ecf_pkg::EDGE_SLOTS);

  // low COORD_BITS of the position, read as two's complement
  assign wr_x = ecf_pkg::coord_t'(in_chan.pos_x);
  assign wr_y = ecf_pkg::coord_t'(in_chan.pos_y);

  ecf_ram #(.WIDTH(ecf_pkg::COORD_BITS), .DEPTH(ecf_pkg::NODE_SLOTS)) u_node_x_ram (
    .clk       (clk),
    .we        (node_we),
    .wr_addr   (ecf_pkg::NODE_AW'(in_chan.node_index)),
    .wr_data   (wr_x),
    .rd_addr   (ecf_pkg::NODE_AW'(node_rd_idx)),
    .rd_data_r (node_x_rd)
  );

  ecf_ram #(.WIDTH(ecf_pkg::COORD_BITS), .DEPTH(ecf_pkg::NODE_SLOTS)) u_node_y_ram (
    .clk       (clk),
    .we        (node_we),
    .wr_addr   (ecf_pkg::NODE_AW'(in_chan.node_index)),
    .wr_data   (wr_y),
    .rd_addr   (ecf_pkg::NODE_AW'(node_rd_idx)),
    .rd_data_r (node_y_rd)
  );

  ecf_ram #(.WIDTH(NIW), .DEPTH(ecf_pkg::EDGE_SLOTS)) u_edge_a_ram (
    .clk       (clk),
    .we        (edge_we),
    .wr_addr   (ecf_pkg::EDGE_AW'(in_chan.edge_index)),
    .wr_data   (in_chan.end_a),
    .rd_addr   (edge_rd_addr),
    .rd_data_r (edge_a_rd)
  );

  ecf_ram #(.WIDTH(NIW), .DEPTH(ecf_pkg::EDGE_SLOTS)) u_edge_b_ram (
    .clk       (clk),
    .we        (edge_we),
    .wr_addr   (ecf_pkg::EDGE_AW'(in_chan.edge_index)),
    .wr_data   (in_chan.end_b),
    .rd_addr   (edge_rd_addr),
    .rd_data_r (edge_b_rd)
  );

  // --------------------------------------------------------------------------
  // status terms
  // --------------------------------------------------------------------------
  logic [JW-1:0]    n_lim;
  logic             j_more, head_oob, shared, pair_crosses, out_free;
  logic [NIW-1:0]   head_a, head_b;
  ecf_pkg::coord_t  node_x, node_y;

  // edges_in_use above the store size acts as the store size
  assign n_lim    = (int'(edges_in_use_r) > ecf_pkg::EDGE_SLOTS) ?
                    JW'(ecf_pkg::EDGE_SLOTS) : edges_in_use_r;
  assign j_more   = j_r < n_lim;
  assign head_oob = int'(scan_idx_r) >= ecf_pkg::EDGE_SLOTS;
  assign head_a   = head_oob ? '0 : edge_a_rd;
  assign head_b   = head_oob ? '0 : edge_b_rd;
  assign shared   = (fa_r == edge_a_rd) || (fa_r == edge_b_rd) ||
                    (fb_r == edge_a_rd) || (fb_r == edge_b_rd);
  // AB crosses CD: A and B on opposite sides of CD, C and D of AB
  assign pair_crosses = (orient_r[0] != orient_r[1]) && (orient_r[2] != orient_r[3]);
  assign out_free = !out_vld_r || out_chan.ready;
  assign node_x   = $signed(node_x_rd);
  assign node_y   = $signed(node_y_rd);

  // --------------------------------------------------------------------------
  // sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ecf_pkg::ST_IDLE: begin
        if (in_xfer && (ecf_pkg::op_t'(in_chan.op) == ecf_pkg::OP_SCAN)) begin
          state_nxt = ecf_pkg::ST_HEAD_EDGE;
        end
      end
      ecf_pkg::ST_HEAD_EDGE: state_nxt = ecf_pkg::ST_HEAD_A;
      ecf_pkg::ST_HEAD_A:    state_nxt = ecf_pkg::ST_HEAD_B;
      ecf_pkg::ST_HEAD_B:    state_nxt = ecf_pkg::ST_J_CHECK;
      ecf_pkg::ST_J_CHECK: begin
        state_nxt = j_more ? ecf_pkg::ST_EDGE_DATA : ecf_pkg::ST_FINISH;
      end
      ecf_pkg::ST_EDGE_DATA: begin
        state_nxt = shared ? ecf_pkg::ST_J_CHECK : ecf_pkg::ST_NODE_C;
      end
      ecf_pkg::ST_NODE_C:    state_nxt = ecf_pkg::ST_NODE_D;
      ecf_pkg::ST_NODE_D:    state_nxt = ecf_pkg::ST_TEST;
      ecf_pkg::ST_TEST: begin
        if (ph_r == ecf_pkg::PH_W'(ecf_pkg::PH_LAST)) begin
          state_nxt = ecf_pkg::ST_DECIDE;
        end
      end
      ecf_pkg::ST_DECIDE: begin
        // a new crossing pushes the held one out; wait if the result is full
        if (!(pair_crosses && pend_vld_r && !out_free)) begin
          state_nxt = ecf_pkg::ST_J_CHECK;
        end
      end
      ecf_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = ecf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ecf_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer: outputs
  // --------------------------------------------------------------------------
  logic in_rdy, issue, take_cross, push_pend, finish_load;

  always_comb begin
    in_rdy       = 1'b0;
    issue        = 1'b0;
    take_cross   = 1'b0;
    push_pend    = 1'b0;
    finish_load  = 1'b0;
    edge_rd_addr = '0;
    node_rd_idx  = '0;
    case (state_r)
      ecf_pkg::ST_IDLE: begin
        in_rdy       = 1'b1;
        edge_rd_addr = ecf_pkg::EDGE_AW'(in_chan.edge_index);
      end
      ecf_pkg::ST_HEAD_EDGE: node_rd_idx = head_a;
      ecf_pkg::ST_HEAD_A:    node_rd_idx = fb_r;
      ecf_pkg::ST_J_CHECK:   edge_rd_addr = ecf_pkg::EDGE_AW'(j_r);
      ecf_pkg::ST_EDGE_DATA: node_rd_idx = edge_a_rd;
      ecf_pkg::ST_NODE_C:    node_rd_idx = sb_r;
      ecf_pkg::ST_TEST: begin
        issue = int'(ph_r) < ecf_pkg::PH_ISSUE;
      end
      ecf_pkg::ST_DECIDE: begin
        take_cross = pair_crosses && (!pend_vld_r || out_free);
        push_pend  = take_cross && pend_vld_r;
      end
      ecf_pkg::ST_FINISH: finish_load = out_free;
      default: ;
    endcase
  end

  assign in_chan.ready = in_rdy;

  // --------------------------------------------------------------------------
  // orientation operand select
  // ccw(P,Q,R): (Ry-Py)*(Qx-Px) > (Qy-Py)*(Rx-Px); even phase gives the
  // left product, odd phase the right one. Test k of ph[2:1]:
  //   0 (A,C,D)  1 (B,C,D)  2 (A,B,C)  3 (A,B,D)
  // --------------------------------------------------------------------------
  ecf_pkg::coord_t px, py, qx, qy, rx, ry, u1, u0, v1, v0;

  always_comb begin
    px = ax_r; py = ay_r;
    qx = cx_r; qy = cy_r;
    rx = dx_r; ry = dy_r;
    case (ph_r[2:1])
      2'd0: begin
        px = ax_r; py = ay_r; qx = cx_r; qy = cy_r; rx = dx_r; ry = dy_r;
      end
      2'd1: begin
        px = bx_r; py = by_r; qx = cx_r; qy = cy_r; rx = dx_r; ry = dy_r;
      end
      2'd2: begin
        px = ax_r; py = ay_r; qx = bx_r; qy = by_r; rx = cx_r; ry = cy_r;
      end
      default: begin
        px = ax_r; py = ay_r; qx = bx_r; qy = by_r; rx = dx_r; ry = dy_r;
      end
    endcase
    if (!ph_r[0]) begin
      u1 = ry; u0 = py; v1 = qx; v0 = px;
    end else begin
      u1 = qy; u0 = py; v1 = rx; v0 = px;
    end
  end

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ecf_pkg::ST_IDLE;
      edges_in_use_r <= '0;
      out_vld_r      <= 1'b0;
      pend_vld_r     <= 1'b0;
      diff_vld_r     <= 1'b0;
      prod_vld_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      diff_vld_r <= issue;
      prod_vld_r <= diff_vld_r;
      if (cfg_we) begin
        edges_in_use_r <= cfg_wdata;
      end
      if (push_pend || finish_load) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
      if (take_cross) begin
        pend_vld_r <= 1'b1;
      end else if (finish_load) begin
        pend_vld_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state_r)
      ecf_pkg::ST_IDLE: begin
        scan_idx_r <= in_chan.edge_index;
        j_r        <= JW'(in_chan.edge_index) + JW'(1);
      end
      ecf_pkg::ST_HEAD_EDGE: begin
        fa_r <= head_a;
        fb_r <= head_b;
      end
      ecf_pkg::ST_HEAD_A: begin
        // endpoints outside the node store sit at the origin
        ax_r <= (int'(fa_r) < ecf_pkg::NODE_SLOTS) ? node_x : '0;
        ay_r <= (int'(fa_r) < ecf_pkg::NODE_SLOTS) ? node_y : '0;
      end
      ecf_pkg::ST_HEAD_B: begin
        bx_r <= (int'(fb_r) < ecf_pkg::NODE_SLOTS) ? node_x : '0;
        by_r <= (int'(fb_r) < ecf_pkg::NODE_SLOTS) ? node_y : '0;
      end
      ecf_pkg::ST_EDGE_DATA: begin
        sa_r <= edge_a_rd;
        sb_r <= edge_b_rd;
        if (shared) begin
          j_r <= j_r + JW'(1);
        end
      end
      ecf_pkg::ST_NODE_C: begin
        cx_r <= (int'(sa_r) < ecf_pkg::NODE_SLOTS) ? node_x : '0;
        cy_r <= (int'(sa_r) < ecf_pkg::NODE_SLOTS) ? node_y : '0;
      end
      ecf_pkg::ST_NODE_D: begin
        dx_r <= (int'(sb_r) < ecf_pkg::NODE_SLOTS) ? node_x : '0;
        dy_r <= (int'(sb_r) < ecf_pkg::NODE_SLOTS) ? node_y : '0;
        ph_r <= '0;
      end
      ecf_pkg::ST_TEST: ph_r <= ph_r + ecf_pkg::PH_W'(1);
      ecf_pkg::ST_DECIDE: begin
        if (!pair_crosses || take_cross) begin
          j_r <= j_r + JW'(1);
        end
        if (take_cross) begin
          pend_edge_r <= EIW'(j_r);
          pend_a_r    <= sa_r;
          pend_b_r    <= sb_r;
        end
      end
      default: ;
    endcase

    // shared unit
    if (issue) begin
      diff_u_r   <= ecf_pkg::diff_t'(u1) - ecf_pkg::diff_t'(u0);
      diff_v_r   <= ecf_pkg::diff_t'(v1) - ecf_pkg::diff_t'(v0);
      diff_tag_r <= ph_r[2:0];
    end
    prod_r     <= diff_u_r * diff_v_r;
    prod_tag_r <= diff_tag_r;
    if (prod_vld_r) begin
      if (!prod_tag_r[0]) begin
        p1_r <= prod_r;
      end else begin
        orient_r[prod_tag_r[2:1]] <= p1_r > prod_r;
      end
    end

    // result register
    if (push_pend || finish_load) begin
      out_first_edge_r  <= scan_idx_r;
      out_first_a_r     <= fa_r;
      out_first_b_r     <= fb_r;
      out_second_edge_r <= pend_vld_r ? pend_edge_r : '0;
      out_second_a_r    <= pend_vld_r ? pend_a_r : '0;
      out_second_b_r    <= pend_vld_r ? pend_b_r : '0;
      out_crossing_r    <= pend_vld_r;
      out_last_r        <= finish_load;
    end
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.first_edge  = out_first_edge_r;
  assign out_chan.second_edge = out_second_edge_r;
  assign out_chan.first_a     = out_first_a_r;
  assign out_chan.first_b     = out_first_b_r;
  assign out_chan.second_a    = out_second_a_r;
  assign out_chan.second_b    = out_second_b_r;
  assign out_chan.crossing    = out_crossing_r;
  assign out_chan.last        = out_last_r;

endmodule

// File: rtl/core/ecf_ram.sv
// ----------------------------------------------------------------------------
// ecf_ram : generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ecf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

// File: rtl/core/ecf_checker.sv
// ----------------------------------------------------------------------------
// ecf_checker : port-level assertions for the edge crossing finder
// Watches the channel ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module ecf_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [ecf_pkg::OP_W-1:0]          in_op,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [ecf_pkg::EDGE_IDX_W-1:0]    out_first_edge,
  input  logic [ecf_pkg::EDGE_IDX_W-1:0]    out_second_edge,
  input  logic [ecf_pkg::NODE_IDX_W-1:0]    out_second_a,
  input  logic [ecf_pkg::NODE_IDX_W-1:0]    out_second_b,
  input  logic                              out_crossing,
  input  logic                              out_last
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its edge indices and its crossing and last flags
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_first_edge) && $stable(out_second_edge)
                                && $stable(out_crossing) && $stable(out_last))
    else $error("result payload changed while stalled");

  // a scan transfer closes the input for the scan
  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == ecf_pkg::OP_SCAN) |=> !in_ready)
    else $error("input ready during scan");

  // loads and unused ops leave the input open
  a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op != ecf_pkg::OP_SCAN) |=> in_ready)
    else $error("input closed after a load");

  // the empty-scan result is final and has its pair edge and pair endpoints cleared
  a_empty_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_crossing |-> out_last && (out_second_edge == '0)
                                   && (out_second_a == '0) && (out_second_b == '0))
    else $error("malformed empty-scan result");

endmodule

bind edge_crossing_finder ecf_checker u_ecf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .in_op           (in_chan.op),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_first_edge  (out_chan.first_edge),
  .out_second_edge (out_chan.second_edge),
  .out_second_a    (out_chan.second_a),
  .out_second_b    (out_chan.second_b),
  .out_crossing    (out_chan.crossing),
  .out_last        (out_chan.last)
);

// File: bench/tb_edge_crossing_finder.sv
// ----------------------------------------------------------------------------
// tb_edge_crossing_finder : self-checking bench for the edge crossing finder
// Loads node positions and edges, scans edges against later ones and checks
// every reported crossing against a cycle-free predictor held in the bench.
// Both channels idle and stall at random; two long result hold-offs per run
// back the block up into its input.
// ----------------------------------------------------------------------------
module tb_edge_crossing_finder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OPW = ecf_pkg::OP_W;
  localparam int NIW = ecf_pkg::NODE_IDX_W;
  localparam int PW  = ecf_pkg::POS_W;
  localparam int EIW = ecf_pkg::EDGE_IDX_W;
  localparam int CW  = ecf_pkg::EIU_W;

  // op code the block ignores
  localparam logic [OPW-1:0] OP_UNUSED = 2'd3;

  localparam int unsigned IDLE_LIMIT   = 20000; // cycles with no transfer at all
  localparam int unsigned DRAIN_CYCLES = 16;    // settle time once nothing is due
  localparam int unsigned LONG_HOLD    = 400;   // receiver hold-off, in cycles
  localparam int unsigned PHASE_ITEMS  = 48;

  typedef struct {
    logic [OPW-1:0]        op;
    logic [NIW-1:0]        node_index;
    logic signed [PW-1:0]  pos_x;
    logic signed [PW-1:0]  pos_y;
    logic [EIW-1:0]        edge_index;
    logic [NIW-1:0]        end_a;
    logic [NIW-1:0]        end_b;
  } cmd_t;

  typedef struct {
    logic [EIW-1:0]        first_edge;
    logic [EIW-1:0]        second_edge;
    logic [NIW-1:0]        first_a;
    logic [NIW-1:0]        first_b;
    logic [NIW-1:0]        second_a;
    logic [NIW-1:0]        second_b;
    logic                  crossing;
    logic                  last;
  } crossing_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CW-1:0] cfg_wdata;

  ecf_in_if  in_chan ();
  ecf_out_if out_chan ();

  edge_crossing_finder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: bench copy of the stores, updated on each accepted transfer, and
  // of edges_in_use. Expected results go to crossings_due in scan order.
  // --------------------------------------------------------------------------
  ecf_pkg::coord_t       pos_x_ram [ecf_pkg::NODE_SLOTS];
  ecf_pkg::coord_t       pos_y_ram [ecf_pkg::NODE_SLOTS];
  logic [NIW-1:0]        end_a_ram [ecf_pkg::EDGE_SLOTS];
  logic [NIW-1:0]        end_b_ram [ecf_pkg::EDGE_SLOTS];
  int unsigned           edges_live;
  crossing_t             crossings_due [$];

  // strict counter-clockwise test on exact 64-bit products
  function automatic bit turns_left(longint px, longint py, longint qx, longint qy,
                                    longint rx, longint ry);
    return (ry - py) * (qx - px) > (qy - py) * (rx - px);
  endfunction

  function automatic bit properly_cross(int a, int b, int c, int d);
    longint ax, ay, bx, by, cx, cy, dx, dy;
    ax = longint'(pos_x_ram[a]); ay = longint'(pos_y_ram[a]);
    bx = longint'(pos_x_ram[b]); by = longint'(pos_y_ram[b]);
    cx = longint'(pos_x_ram[c]); cy = longint'(pos_y_ram[c]);
    dx = longint'(pos_x_ram[d]); dy = longint'(pos_y_ram[d]);
    return (turns_left(ax, ay, cx, cy, dx, dy) != turns_left(bx, by, cx, cy, dx, dy))
        && (turns_left(ax, ay, bx, by, cx, cy) != turns_left(ax, ay, bx, by, dx, dy));
  endfunction

  function automatic void apply_command(cmd_t c);
    int        span;
    int        i;
    int        hits;
    crossing_t r;
    hits = 0;
    case (c.op)
      ecf_pkg::OP_LOAD_NODE: begin
        pos_x_ram[c.node_index] = c.pos_x;
        pos_y_ram[c.node_index] = c.pos_y;
      end
      ecf_pkg::OP_LOAD_EDGE: begin
        end_a_ram[c.edge_index] = c.end_a;
        end_b_ram[c.edge_index] = c.end_b;
      end
      ecf_pkg::OP_SCAN: begin
        // register values above the slot count act as a full list
        span = (edges_live > ecf_pkg::EDGE_SLOTS) ? ecf_pkg::EDGE_SLOTS : int'(edges_live);
        i    = int'(c.edge_index);
        r.first_edge = c.edge_index;
        r.first_a    = end_a_ram[i];
        r.first_b    = end_b_ram[i];
        r.crossing   = 1'b1;
        r.last       = 1'b0;
        for (int j = i + 1; j < span; j++) begin
          // shared endpoint: skipped without a test
          if (r.first_a == end_a_ram[j] || r.first_a == end_b_ram[j] ||
              r.first_b == end_a_ram[j] || r.first_b == end_b_ram[j])
            continue;
          if (!properly_cross(int'(r.first_a), int'(r.first_b),
                              int'(end_a_ram[j]), int'(end_b_ram[j])))
            continue;
          r.second_edge = EIW'(j);
          r.second_a    = end_a_ram[j];
          r.second_b    = end_b_ram[j];
          crossings_due.push_back(r);
          hits++;
        end
        if (hits == 0) begin
          // nothing crosses: one closing result with the pair fields cleared
          r.second_edge = '0;
          r.second_a    = '0;
          r.second_b    = '0;
          r.crossing    = 1'b0;
          r.last        = 1'b1;
          crossings_due.push_back(r);
        end else begin
          crossings_due[crossings_due.size() - 1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Command generation. Keeps its own record of which entries have been
  // written so that no scan ever reads an unwritten edge or node.
  // --------------------------------------------------------------------------
  cmd_t        cmd_queue [$];
  int unsigned queued_cnt;
  int unsigned taken_cnt;
  int unsigned issued;
  bit          node_loaded [ecf_pkg::NODE_SLOTS];
  bit          edge_loaded [ecf_pkg::EDGE_SLOTS];
  int          loaded_nodes [$];
  int          span_gen;

  function automatic cmd_t noise_cmd();
    cmd_t c;
    c.op         = OPW'($urandom_range(0, 3));
    c.node_index = NIW'($urandom);
    c.pos_x      = PW'($urandom);
    c.pos_y      = PW'($urandom);
    c.edge_index = EIW'($urandom);
    c.end_a      = NIW'($urandom);
    c.end_b      = NIW'($urandom);
    return c;
  endfunction

  function automatic void push_cmd(cmd_t c);
    cmd_queue.push_back(c);
    queued_cnt++;
    if (c.op != OP_UNUSED) issued++;
  endfunction

  function automatic void load_node(int idx, int x, int y);
    cmd_t c;
    c = noise_cmd();
    c.op         = ecf_pkg::OP_LOAD_NODE;
    c.node_index = NIW'(idx);
    c.pos_x      = PW'(x);
    c.pos_y      = PW'(y);
    if (!node_loaded[idx]) begin
      node_loaded[idx] = 1'b1;
      loaded_nodes.push_back(idx);
    end
    push_cmd(c);
  endfunction

  function automatic void load_edge(int idx, int a, int b);
    cmd_t c;
    c = noise_cmd();
    c.op         = ecf_pkg::OP_LOAD_EDGE;
    c.edge_index = EIW'(idx);
    c.end_a      = NIW'(a);
    c.end_b      = NIW'(b);
    edge_loaded[idx] = 1'b1;
    push_cmd(c);
  endfunction

  function automatic int any_node();
    return loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
  endfunction

  // a scan reads the scanned edge and every later edge in use: fill gaps first
  function automatic void scan(int idx);
    cmd_t c;
    int   stop;
    stop = (idx + 1 > span_gen) ? idx + 1 : span_gen;
    for (int j = idx; j < stop; j++)
      if (!edge_loaded[j]) load_edge(j, any_node(), any_node());
    c = noise_cmd();
    c.op         = ecf_pkg::OP_SCAN;
    c.edge_index = EIW'(idx);
    push_cmd(c);
  endfunction

  // small grid for collinear cases, full range, or the extremes
  function automatic int pick_coord(int mode);
    case (mode)
      0:       return int'($urandom_range(0, 6)) - 3;
      1:       return int'($urandom_range(0, 65535)) - 32768;
      default: begin
        case ($urandom_range(0, 4))
          0:       return -32768;
          1:       return 32767;
          2:       return 0;
          3:       return -1;
          default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: bursts of transfers with random gaps, fed from cmd_queue.
  // Fields change on the falling edge; the transfer is seen on the rising one.
  // --------------------------------------------------------------------------
  cmd_t        cur_cmd;
  bit          in_took;
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready) begin
      in_took <= 1'b1;
      taken_cnt++;
      apply_command(cur_cmd);
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_chan.valid || in_took)) begin
      if (in_took) in_took <= 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        in_chan.valid <= 1'b0;
      end else if (cmd_queue.size() != 0) begin
        cur_cmd = cmd_queue.pop_front();
        in_chan.op         <= cur_cmd.op;
        in_chan.node_index <= cur_cmd.node_index;
        in_chan.pos_x      <= cur_cmd.pos_x;
        in_chan.pos_y      <= cur_cmd.pos_y;
        in_chan.edge_index <= cur_cmd.edge_index;
        in_chan.end_a      <= cur_cmd.end_a;
        in_chan.end_b      <= cur_cmd.end_b;
        in_chan.valid      <= 1'b1;
        if (burst_left != 0) burst_left--;
        if (burst_left == 0) begin
          // now and then a long stretch with no gaps at all
          if ($urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(40, 120);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = $urandom_range(0, 10);
          end
        end
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: ready pattern switches between modes every so often, and twice
  // a long hold-off so the block stalls mid-scan and blocks its input.
  // --------------------------------------------------------------------------
  int unsigned hold_left;
  int unsigned holds_done;
  int unsigned mode_left;
  int unsigned results_seen;
  int unsigned rx_cycle;
  int          rx_mode;

  always @(negedge clk) begin
    if (rst_n) begin
      rx_cycle++;
      if (hold_left == 0 && holds_done < 2 &&
          results_seen >= ((holds_done == 0) ? 30 : 150)) begin
        hold_left = LONG_HOLD;
        holds_done++;
      end
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_chan.ready <= 1'b1;
          1:       out_chan.ready <= ($urandom_range(0, 1) == 1);
          2:       out_chan.ready <= ($urandom_range(0, 3) == 0);
          default: out_chan.ready <= ((rx_cycle % 8) < 3);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: each transfer against the oldest expectation.
  // --------------------------------------------------------------------------
  int unsigned mismatches;

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    crossing_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (crossings_due.size() == 0) begin
        $error("result transfer with nothing expected (first_edge %0d)",
               out_chan.first_edge);
        mismatches++;
      end else begin
        want = crossings_due.pop_front();
        check_field("first_edge",  int'(want.first_edge),  int'(out_chan.first_edge));
        check_field("second_edge", int'(want.second_edge), int'(out_chan.second_edge));
        check_field("first_a",     int'(want.first_a),     int'(out_chan.first_a));
        check_field("first_b",     int'(want.first_b),     int'(out_chan.first_b));
        check_field("second_a",    int'(want.second_a),    int'(out_chan.second_a));
        check_field("second_b",    int'(want.second_b),    int'(out_chan.second_b));
        check_field("crossing",    int'(want.crossing),    int'(out_chan.crossing));
        check_field("last",        int'(want.last),        int'(out_chan.last));
      end
    end
  end

  // watchdog: a long stretch with no transfer on either channel ends the run
  int unsigned quiet;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= IDLE_LIMIT) begin
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed set, then random phases at several settings.
  // --------------------------------------------------------------------------

  // wait for every transfer and result, then let the sequencer settle
  task automatic drain();
    while (taken_cnt != queued_cnt || crossings_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // only ever called with the block idle
  task automatic write_edges_in_use(int unsigned v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CW'(v);
    @(negedge clk);
    cfg_we     <= 1'b0;
    edges_live  = v;
    span_gen    = (v > ecf_pkg::EDGE_SLOTS) ? ecf_pkg::EDGE_SLOTS : int'(v);
  endtask

  task automatic run_phase(int unsigned setting);
    int unsigned target;
    int          r;
    int          idx;
    int          a;
    int          mode;
    cmd_t        c;
    write_edges_in_use(setting);
    target = issued + PHASE_ITEMS;
    while (issued < target) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        // half the time move a node already in use, so geometry keeps changing
        idx  = ($urandom_range(0, 1) == 0) ? any_node() :
               $urandom_range(0, ecf_pkg::NODE_SLOTS - 1);
        mode = $urandom_range(0, 2);
        load_node(idx, pick_coord(mode), pick_coord(mode));
      end else if (r < 30) begin
        idx = (span_gen > 0 && $urandom_range(0, 4) != 0) ?
              $urandom_range(0, span_gen - 1) : $urandom_range(0, ecf_pkg::EDGE_SLOTS - 1);
        a   = any_node();
        // occasional zero-length edge
        load_edge(idx, a, ($urandom_range(0, 9) == 0) ? a : any_node());
      end else if (r < 95) begin
        idx = (span_gen > 0 && $urandom_range(0, 6) != 0) ?
              $urandom_range(0, span_gen - 1) : $urandom_range(0, ecf_pkg::EDGE_SLOTS - 1);
        scan(idx);
      end else begin
        // ignored op code, random fields
        c    = noise_cmd();
        c.op = OP_UNUSED;
        push_cmd(c);
      end
    end
    drain();
  endtask

  initial begin
    cmd_t c;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_chan.valid       = 1'b0;
    in_chan.op          = '0;
    in_chan.node_index  = '0;
    in_chan.pos_x       = '0;
    in_chan.pos_y       = '0;
    in_chan.edge_index  = '0;
    in_chan.end_a       = '0;
    in_chan.end_b       = '0;
    out_chan.ready      = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed set. Corner-to-corner diagonals cross just off the origin, at
    // (-1/2,-1/2), with the widest differences the coordinates allow.
    write_edges_in_use(6);
    c    = noise_cmd();
    c.op = OP_UNUSED;
    push_cmd(c);
    load_node(0,   -32768, -32768);
    load_node(255,  32767,  32767);
    load_node(1,   -32768,  32767);
    load_node(2,    32767, -32768);
    load_node(3,        0,      0);
    load_node(4,      100,    100);
    load_node(5,        0,    100);
    load_node(6,      100,      0);
    load_node(7,      -50,     50);
    load_edge(0, 0, 255);  // main diagonal
    load_edge(1, 1, 2);    // anti-diagonal, crosses edge 0
    load_edge(2, 3, 4);    // collinear with edge 0, starts at the origin, clear of edge 1
    load_edge(3, 5, 6);    // crosses edges 0 and 2 at (50,50)
    load_edge(4, 4, 4);    // zero length, shares node 4 with edge 2
    load_edge(5, 3, 7);    // parallel to edge 1, endpoint on edge 0
    load_edge(63, 255, 0); // beyond the edges in use, reversed edge 0
    scan(0);
    scan(2);
    scan(5);               // last edge in use: empty scan
    scan(63);              // index past the edges in use: empty scan
    drain();

    // random phases, register extremes among them
    run_phase(64);
    run_phase(127);
    run_phase(0);
    run_phase(1);
    run_phase(2);
    run_phase($urandom_range(3, 63));
    run_phase($urandom_range(65, 126));
    run_phase(64);
    run_phase($urandom_range(3, 63));

    if (mismatches == 0 && crossings_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
